### src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and round functions for the AES-128 unit.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Byte i of a block sits at bits [127-8i -: 8]; byte index = row + 4*col.
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] isb(input logic [7:0] a);
    isb = ISBOX[a];
  endfunction

  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    gb = s[127-8*i -: 8];
  endfunction

  // Forward round body: SubBytes, ShiftRows, optional MixColumns.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[gb(s, r + 4*((c+r)%4))];
      end
    end
    enc_round = t;
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = gb(t, 4*c); a1 = gb(t, 4*c+1); a2 = gb(t, 4*c+2); a3 = gb(t, 4*c+3);
        enc_round[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        enc_round[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        enc_round[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        enc_round[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
  endfunction

  // Inverse ShiftRows and inverse SubBytes.
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        dec_sub[127-8*(r+4*((c+r)%4)) -: 8] = isb(gb(s, r + 4*c));
      end
    end
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
      // Premultiply trick: inverse mix = forward mix of adjusted column.
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      inv_mix[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      inv_mix[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      inv_mix[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      inv_mix[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
  endfunction

  // One step of the key schedule.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage

### src/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the key registers and a registered copy of all eleven round keys.
// ----------------------------------------------------------------------------
module aes_key_sched
  import aes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [63:0]          cfg_data,
  output logic [127:0]         round_key [NumRounds+1]
);

  logic [127:0] key;
  logic [7:0]   rcon [NumRounds];

  assign rcon = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HIGH: key[127:64] <= cfg_data;
        REG_KEY_LOW:  key[63:0]   <= cfg_data;
        default:      key         <= key;
      endcase
    end
  end

  // One schedule step per register; a key write ripples down the chain, and
  // the user, not the block, must let it settle before the next item.
  always_ff @(posedge clk) begin
    round_key[0] <= key;
    for (int i = 1; i <= NumRounds; i++) begin
      round_key[i] <= key_step(round_key[i-1], rcon[i-1]);
    end
  end

endmodule

### src/aes128_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-128 ECB block cipher unit
// Fully unrolled, one round per pipeline stage, encrypt or decrypt per block.
// ----------------------------------------------------------------------------
// The unit takes one 128-bit block per cycle while in_stall is low and
// returns it encrypted or decrypted with the current key (one stage for the
// initial key addition, one per round). Every stage holds a valid bit and
// advances only when the stage after it is free, so back-pressure from the
// output stalls the pipe without losing or repeating a transfer. Round keys
// are worked out from the key registers by a registered schedule whose
// settling cycles follow each key write; write the key only while the
// unit is idle and leave those cycles before the next block.
module aes128_block_cipher_unit
  import aes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aes_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aes_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [127:0] round_key [NumRounds+1];

  // Stage 0 holds the block after the first key addition; stage NumRounds
  // is the output register.
  logic         vld   [NumRounds+1];
  logic         dec   [NumRounds+1];
  logic [127:0] st    [NumRounds+1];
  logic         adv   [NumRounds+1];

  assign cfg_ready = 1'b1;

  aes_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .round_key (round_key)
  );

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv[NumRounds] = !vld[NumRounds] || !out_stall;
    for (int i = NumRounds - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NumRounds; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= adv[0] ? in_valid : vld[0];
      for (int i = 1; i <= NumRounds; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Datapath. Decryption uses the inverse cipher order: stage i applies
  // inverse shift/sub, key addition, then inverse mix (not on the last).
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dec[0] <= in_data.kind;
      st[0]  <= {in_data.data_high, in_data.data_low} ^
                (in_data.kind == OP_DECRYPT ? round_key[NumRounds] : round_key[0]);
    end
    for (int i = 1; i <= NumRounds; i++) begin
      if (adv[i]) begin
        dec[i] <= dec[i-1];
        if (dec[i-1] == OP_DECRYPT) begin
          if (i == NumRounds) st[i] <= dec_sub(st[i-1]) ^ round_key[0];
          else st[i] <= inv_mix(dec_sub(st[i-1]) ^ round_key[NumRounds-i]);
        end else begin
          st[i] <= enc_round(st[i-1], i != NumRounds) ^ round_key[i];
        end
      end
    end
  end

  assign out_valid = vld[NumRounds];
  assign out_data  = '{result_high: st[NumRounds][127:64], result_low: st[NumRounds][63:0]};

endmodule

### src/aes_checker.sv
// ----------------------------------------------------------------------------
// AES port checker
// Watches the ports of the cipher unit for handshake and reset behaviour.
// ----------------------------------------------------------------------------
module aes_checker
  import aes_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input aes_out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Nothing comes out right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // Input is only stalled while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

endmodule

bind aes128_block_cipher_unit aes_checker u_aes_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
